>>> sv/pflcd_pkg.sv
// Shared types and constants for the palette frame to LCD streamer.
// No dependencies; used by every module of the block.
package pflcd_pkg;

   localparam logic [1:0] CMD_PALETTE = 2'd0;
   localparam logic [1:0] CMD_FRAME   = 2'd1;
   localparam logic [1:0] CMD_PIXEL   = 2'd2;

   localparam logic [7:0] OP_CASET = 8'h2A;
   localparam logic [7:0] OP_RASET = 8'h2B;
   localparam logic [7:0] OP_RAMWR = 8'h2C;

   localparam logic [7:0] CSR_FRAME_WIDTH  = 8'd0;
   localparam logic [7:0] CSR_FRAME_HEIGHT = 8'd1;

   localparam logic [8:0] RESET_WIDTH  = 9'd320;
   localparam logic [8:0] RESET_HEIGHT = 9'd240;

   localparam int DIM_W       = 9;
   localparam int CNT_W       = 18;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic             is_window;
      logic [DIM_W-1:0] x0;
      logic [DIM_W-1:0] x1;
      logic [DIM_W-1:0] y0;
      logic [DIM_W-1:0] y1;
      logic [15:0]      color;
      logic             fend;
   } job_type;

endpackage

>>> sv/pflcd_front.sv
// Front end: accepts transactions, keeps the palette and frame state, and
// builds window and pixel jobs for the queue. Depends on pflcd_pkg.
module pflcd_front #(
   parameter int PANEL_WIDTH     = 320,
   parameter int PANEL_HEIGHT    = 320,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_palette_slot,
   input  logic [23:0]            req_color_rgb888,
   input  logic [7:0]             req_pixel_index,
   input  pflcd_pkg::cfg_type     cfg,
   output logic                   push,
   output pflcd_pkg::job_type     push_job,
   input  logic                   q_ready
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);

   logic [15:0] mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_valid_ff;
   logic [15:0] pal_data_ff;
   logic        pal_ok_ff;

   logic                            active_ff, active_in;
   logic [pflcd_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                            s1_valid_ff, s1_valid_in;
   pflcd_pkg::job_type              s1_job_ff, s1_job_in;

   logic accept;
   logic slot_ok, idx_ok;
   logic [IDX_W-1:0] slot_idx, pix_idx;
   logic [15:0] rgb565;
   logic frame_ok;
   logic [pflcd_pkg::DIM_W-1:0] x0, x1, y0, y1;
   logic [pflcd_pkg::CNT_W-1:0] count_inc, area;
   logic fend;

   assign req_stall = s1_valid_ff && !q_ready;
   assign accept    = req_valid && !req_stall;
   assign push      = s1_valid_ff && q_ready;

   assign slot_ok  = {1'b0, req_palette_slot} < 9'(PALETTE_ENTRIES);
   assign idx_ok   = {1'b0, req_pixel_index} < 9'(PALETTE_ENTRIES);
   assign slot_idx = req_palette_slot[IDX_W-1:0];
   assign pix_idx  = req_pixel_index[IDX_W-1:0];
   assign rgb565   = {req_color_rgb888[23:19], req_color_rgb888[15:10], req_color_rgb888[7:3]};

   always_comb begin
      frame_ok = (cfg.width != '0) && (cfg.height != '0)
              && (cfg.width <= 9'(PANEL_WIDTH)) && (cfg.height <= 9'(PANEL_HEIGHT));
      x0 = (9'(PANEL_WIDTH) - cfg.width) >> 1;
      y0 = (9'(PANEL_HEIGHT) - cfg.height) >> 1;
      x1 = x0 + cfg.width - 9'd1;
      y1 = y0 + cfg.height - 9'd1;
      count_inc = count_ff + 18'd1;
      area = 18'(cfg.width) * 18'(cfg.height);
      fend = count_inc >= area;
   end

   always_comb begin
      active_in   = active_ff;
      count_in    = count_ff;
      s1_valid_in = push ? 1'b0 : s1_valid_ff;
      s1_job_in   = s1_job_ff;
      if (accept) begin
         case (req_command)
            pflcd_pkg::CMD_FRAME: begin
               active_in           = frame_ok;
               count_in            = '0;
               s1_valid_in         = frame_ok;
               s1_job_in.is_window = 1'b1;
               s1_job_in.x0        = x0;
               s1_job_in.x1        = x1;
               s1_job_in.y0        = y0;
               s1_job_in.y1        = y1;
               s1_job_in.fend      = 1'b0;
            end
            pflcd_pkg::CMD_PIXEL: begin
               if (active_ff) begin
                  s1_valid_in         = 1'b1;
                  s1_job_in.is_window = 1'b0;
                  s1_job_in.fend      = fend;
                  if (fend) begin
                     active_in = 1'b0;
                     count_in  = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      push_job       = s1_job_ff;
      push_job.color = pal_ok_ff ? pal_data_ff : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_job_ff <= s1_job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (accept && req_command == pflcd_pkg::CMD_PALETTE && slot_ok) begin
         pal_valid_ff[slot_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_command == pflcd_pkg::CMD_PALETTE && slot_ok) begin
         mem[slot_idx] <= rgb565;
      end
      if (accept) begin
         pal_data_ff <= mem[pix_idx];
         pal_ok_ff   <= idx_ok && pal_valid_ff[pix_idx];
      end
   end

endmodule

>>> sv/pflcd_queue.sv
// Short job queue between the front end and the byte sequencer.
// Depends on pflcd_pkg for the job type and depth.
module pflcd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pflcd_pkg::job_type push_job,
   output logic               q_ready,
   input  logic               pop,
   output logic               q_nonempty,
   output pflcd_pkg::job_type head_job
);

   localparam int DEPTH = pflcd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   pflcd_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign q_ready    = count_ff != (PTR_W+1)'(DEPTH);
   assign q_nonempty = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (push && !pop) count_ff <= count_ff + (PTR_W+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_nonempty) else $error("queue pop while empty");

endmodule

>>> sv/pflcd_back.sv
// Byte sequencer: walks each queued job and drives the registered result
// channel one byte per cycle while rsp_stall is low. Depends on pflcd_pkg.
module pflcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_nonempty,
   input  pflcd_pkg::job_type head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_is_command,
   output logic               rsp_last,
   output logic               rsp_frame_end
);

   logic [3:0] cnt_ff, cnt_in;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       cmd_ff, cmd_in;
   logic       last_ff, last_in;
   logic       fend_ff, fend_in;
   logic       load, emit;

   assign load = !valid_ff || !rsp_stall;
   assign emit = load && q_nonempty;
   assign pop  = emit && last_in;

   always_comb begin
      byte_in = 8'd0;
      cmd_in  = 1'b0;
      last_in = 1'b0;
      fend_in = 1'b0;
      if (head_job.is_window) begin
         case (cnt_ff)
            4'd0:  begin byte_in = pflcd_pkg::OP_CASET; cmd_in = 1'b1; end
            4'd1:  byte_in = {7'd0, head_job.x0[8]};
            4'd2:  byte_in = head_job.x0[7:0];
            4'd3:  byte_in = {7'd0, head_job.x1[8]};
            4'd4:  byte_in = head_job.x1[7:0];
            4'd5:  begin byte_in = pflcd_pkg::OP_RASET; cmd_in = 1'b1; end
            4'd6:  byte_in = {7'd0, head_job.y0[8]};
            4'd7:  byte_in = head_job.y0[7:0];
            4'd8:  byte_in = {7'd0, head_job.y1[8]};
            4'd9:  byte_in = head_job.y1[7:0];
            default: begin
               byte_in = pflcd_pkg::OP_RAMWR;
               cmd_in  = 1'b1;
               last_in = 1'b1;
            end
         endcase
      end else begin
         if (cnt_ff == 4'd0) begin
            byte_in = head_job.color[15:8];
         end else begin
            byte_in = head_job.color[7:0];
            last_in = 1'b1;
            fend_in = head_job.fend;
         end
      end
      cnt_in = cnt_ff;
      if (emit) cnt_in = last_in ? 4'd0 : cnt_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (load) valid_ff <= q_nonempty;
      end
      if (emit) begin
         byte_ff <= byte_in;
         cmd_ff  <= cmd_in;
         last_ff <= last_in;
         fend_ff <= fend_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_command = cmd_ff;
   assign rsp_last       = last_ff;
   assign rsp_frame_end  = fend_ff;

   a_fend_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last && !rsp_is_command)
      else $error("frame end on a byte that is not a closing data byte");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd10) else $error("byte counter out of range");

endmodule

>>> sv/palette_frame_to_spi_lcd_streamer.sv
// Indexed-color frame streamer for a serial RGB565 panel; top level.
// Depends on pflcd_pkg, pflcd_front, pflcd_queue and pflcd_back.
//
// A palette write gives no bytes. A frame start puts eleven window setup
// bytes on the result channel, one per cycle while rsp_stall is low; a
// pixel gives two bytes, both from the single output register of the
// sequencer. The front end reads the palette through a registered memory
// port and hands jobs to a four-entry queue, so a transaction's first byte
// passes the front-end job register and a queue slot before the output
// register shows it. The palette reads black at reset through per-entry
// valid bits; no clearing pass is needed. The csr port is always ready.
module palette_frame_to_spi_lcd_streamer #(
   parameter int PANEL_WIDTH     = 320,
   parameter int PANEL_HEIGHT    = 320,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_palette_slot,
   input  logic [23:0] req_color_rgb888,
   input  logic [7:0]  req_pixel_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_command,
   output logic        rsp_last,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   pflcd_pkg::cfg_type cfg_ff;
   pflcd_pkg::job_type push_job, head_job;
   logic push, pop, q_ready, q_nonempty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= pflcd_pkg::RESET_WIDTH;
         cfg_ff.height <= pflcd_pkg::RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == pflcd_pkg::CSR_FRAME_WIDTH)  cfg_ff.width  <= csr_wdata;
         if (csr_index == pflcd_pkg::CSR_FRAME_HEIGHT) cfg_ff.height <= csr_wdata;
      end
   end

   pflcd_front #(
      .PANEL_WIDTH     (PANEL_WIDTH),
      .PANEL_HEIGHT    (PANEL_HEIGHT),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_palette_slot (req_palette_slot),
      .req_color_rgb888 (req_color_rgb888),
      .req_pixel_index  (req_pixel_index),
      .cfg              (cfg_ff),
      .push             (push),
      .push_job         (push_job),
      .q_ready          (q_ready)
   );

   pflcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .q_ready    (q_ready),
      .pop        (pop),
      .q_nonempty (q_nonempty),
      .head_job   (head_job)
   );

   pflcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_nonempty     (q_nonempty),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

>>> verif/palette_frame_to_spi_lcd_streamer_test.sv
// Self-checking testbench for palette_frame_to_spi_lcd_streamer: palette writes,
// window setup and pixel bytes are predicted per transaction and compared per byte.
// Depends on pflcd_pkg and the streamer RTL.
`timescale 1ns / 100ps

module palette_frame_to_spi_lcd_streamer_test;

   localparam int PANEL_W = 320;
   localparam int PANEL_H = 320;
   localparam int PALETTE_N = 256;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [7:0] CSR_UNUSED = 8'hFF;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      logic [1:0]  command;
      logic [7:0]  palette_slot;
      logic [23:0] color_rgb888;
      logic [7:0]  pixel_index;
   } lcd_req_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       is_command;
      logic       last;
      logic       frame_end;
   } lcd_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [7:0]  req_palette_slot = '0;
   logic [23:0] req_color_rgb888 = '0;
   logic [7:0]  req_pixel_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_command;
   logic        rsp_last;
   logic        rsp_frame_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;

   lcd_req_type  req_backlog[$];
   lcd_byte_type lcd_bytes_due[$];
   lcd_req_type  req_on_bus;
   int           cycle_count = 0;
   int           mismatch_count = 0;
   int           queued_count = 0;

   // shadow state of the streamer
   logic [15:0] palette_rgb565[PALETTE_N];
   logic        frame_open = 1'b0;
   int unsigned pixels_done = 0;
   int unsigned size_w = pflcd_pkg::RESET_WIDTH;
   int unsigned size_h = pflcd_pkg::RESET_HEIGHT;

   palette_frame_to_spi_lcd_streamer #(
      .PANEL_WIDTH(PANEL_W),
      .PANEL_HEIGHT(PANEL_H),
      .PALETTE_ENTRIES(PALETTE_N)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_palette_slot(req_palette_slot),
      .req_color_rgb888(req_color_rgb888),
      .req_pixel_index(req_pixel_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_command(rsp_is_command),
      .rsp_last(rsp_last),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // gaps at about 7 percent, none while cycle_count % 3000 is at least 2000
   function automatic bit take_gap();
      if ((cycle_count % 3000) >= 2000) return 1'b0;
      return $urandom_range(99) < 7;
   endfunction

   function automatic void due_byte(logic [7:0] b, logic cmd, logic lst, logic fend);
      lcd_byte_type e;
      e.out_byte = b;
      e.is_command = cmd;
      e.last = lst;
      e.frame_end = fend;
      lcd_bytes_due.push_back(e);
   endfunction

   function automatic void due_window(logic [7:0] op, logic [15:0] lo, logic [15:0] hi);
      due_byte(op, 1'b1, 1'b0, 1'b0);
      due_byte(lo[15:8], 1'b0, 1'b0, 1'b0);
      due_byte(lo[7:0], 1'b0, 1'b0, 1'b0);
      due_byte(hi[15:8], 1'b0, 1'b0, 1'b0);
      due_byte(hi[7:0], 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic void predict_lcd_bytes(lcd_req_type r);
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] color;
      logic        fend;
      case (r.command)
         pflcd_pkg::CMD_PALETTE: begin
            palette_rgb565[r.palette_slot] =
               {r.color_rgb888[23:19], r.color_rgb888[15:10], r.color_rgb888[7:3]};
         end
         pflcd_pkg::CMD_FRAME: begin
            pixels_done = 0;
            if (size_w == 0 || size_h == 0 || size_w > PANEL_W || size_h > PANEL_H) begin
               frame_open = 1'b0;
            end else begin
               x0 = 16'((PANEL_W - size_w) / 2);
               y0 = 16'((PANEL_H - size_h) / 2);
               due_window(pflcd_pkg::OP_CASET, x0, 16'(x0 + size_w - 1));
               due_window(pflcd_pkg::OP_RASET, y0, 16'(y0 + size_h - 1));
               due_byte(pflcd_pkg::OP_RAMWR, 1'b1, 1'b1, 1'b0);
               frame_open = 1'b1;
            end
         end
         pflcd_pkg::CMD_PIXEL: begin
            if (frame_open) begin
               color = palette_rgb565[r.pixel_index];
               pixels_done++;
               fend = pixels_done >= size_w * size_h;
               due_byte(color[15:8], 1'b0, 1'b0, 1'b0);
               due_byte(color[7:0], 1'b0, 1'b1, fend);
               if (fend) begin
                  frame_open = 1'b0;
                  pixels_done = 0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_lcd_bytes(req_on_bus);
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && !take_gap()) begin
               req_on_bus = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= req_on_bus.command;
               req_palette_slot <= req_on_bus.palette_slot;
               req_color_rgb888 <= req_on_bus.color_rgb888;
               req_pixel_index <= req_on_bus.pixel_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   // monitor
   always @(posedge clock) begin
      lcd_byte_type e;
      rsp_stall <= take_gap();
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lcd_bytes_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected byte, expected none actual %02h", $time, rsp_out_byte);
         end else begin
            e = lcd_bytes_due.pop_front();
            check_field("out_byte", e.out_byte, rsp_out_byte);
            check_field("is_command", e.is_command, rsp_is_command);
            check_field("last", e.last, rsp_last);
            check_field("frame_end", e.frame_end, rsp_frame_end);
         end
      end
   end

   task automatic queue_req(input logic [1:0] cmd, input logic [7:0] slot,
                            input logic [23:0] rgb, input logic [7:0] idx);
      lcd_req_type r;
      r.command = cmd;
      r.palette_slot = slot;
      r.color_rgb888 = rgb;
      r.pixel_index = idx;
      req_backlog.push_back(r);
      queued_count++;
   endtask

   task automatic queue_rand(input logic [1:0] cmd);
      queue_req(cmd, 8'($urandom), 24'($urandom), 8'($urandom));
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || lcd_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [8:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == pflcd_pkg::CSR_FRAME_WIDTH) size_w = data;
      else if (idx == pflcd_pkg::CSR_FRAME_HEIGHT) size_h = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_size(input int unsigned w, input int unsigned h);
      settle();
      csr_write(pflcd_pkg::CSR_FRAME_WIDTH, 9'(w));
      csr_write(pflcd_pkg::CSR_FRAME_HEIGHT, 9'(h));
   endtask

   // stimulus
   initial begin
      int unsigned w;
      int unsigned h;
      int          npix;
      int          pick;
      bit          size_ok;
      foreach (palette_rgb565[i]) palette_rgb565[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset size 320 x 240
      queue_req(pflcd_pkg::CMD_PALETTE, 8'd0, 24'hFFFFFF, 8'd0);
      queue_req(pflcd_pkg::CMD_PALETTE, 8'd255, 24'h123456, 8'hFF);
      queue_req(pflcd_pkg::CMD_PALETTE, 8'd1, 24'h070307, 8'd0);
      queue_req(CMD_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd0);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd0);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd255);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd1);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd200);
      queue_req(pflcd_pkg::CMD_PALETTE, 8'd200, 24'hF8FCF8, 8'd0);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd200);
      // restart mid-frame, one pixel frame, then a stray pixel
      set_size(1, 1);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd255);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd0);
      // bad sizes
      set_size(0, 5);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd0);
      set_size(5, 0);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      set_size(321, 320);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      set_size(511, 511);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      // full panel, then shrink while the frame is open
      set_size(PANEL_W, PANEL_H);
      queue_req(pflcd_pkg::CMD_FRAME, 8'd0, 24'd0, 8'd0);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd0);
      settle();
      csr_write(CSR_UNUSED, 9'h1FF);
      set_size(2, 2);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd255);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd200);
      set_size(1, 2);
      queue_req(pflcd_pkg::CMD_PIXEL, 8'd0, 24'd0, 8'd0);

      // random frames
      while (queued_count < 310) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            w = $urandom_range(1) ? 0 : $urandom_range(PANEL_W + 1, 511);
            h = $urandom_range(511);
         end else if (pick < 12) begin
            w = $urandom_range(1) ? PANEL_W : $urandom_range(1, PANEL_W);
            h = $urandom_range(1) ? PANEL_H : $urandom_range(1, PANEL_H);
         end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
         end
         set_size(w, h);
         if ($urandom_range(19) == 0)
            csr_write(8'($urandom_range(2, 255)), 9'($urandom));
         size_ok = w != 0 && h != 0 && w <= PANEL_W && h <= PANEL_H;
         repeat ($urandom_range(3)) begin
            queue_rand(pflcd_pkg::CMD_PALETTE);
         end
         if ($urandom_range(6) != 0) begin
            queue_rand(pflcd_pkg::CMD_FRAME);
         end
         npix = size_ok ? w * h : $urandom_range(1, 3);
         if (npix > 24) npix = $urandom_range(4, 24);
         pick = $urandom_range(9);
         if (pick == 0) npix = $urandom_range(npix);
         else if (pick == 1) npix += 2;
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(19) == 0)
               queue_rand($urandom_range(1) ? CMD_UNUSED : pflcd_pkg::CMD_PALETTE);
            queue_rand(pflcd_pkg::CMD_PIXEL);
         end
      end

      settle();
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
